>>> sv/mrrt_pkg.sv
`default_nettype none
package mrrt_pkg;
	localparam int unsigned NUM_WIDTH = 63;
	localparam int unsigned CNT_W = $clog2(NUM_WIDTH + 1);

	typedef logic [NUM_WIDTH-1:0] num_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// A cell's share of one shift-add modular product.
	typedef struct packed {
		num_t acc;
		num_t part;
		num_t mult;
	} mul_data_t;

	// (x + y) mod n for x, y < n
	function automatic num_t add_mod(num_t x, num_t y, num_t n);
		num_t gap;
		gap = n - y;
		return (x >= gap) ? (x - gap) : (x + y);
	endfunction
endpackage
`default_nettype wire

>>> sv/mrrt_cell.sv
`default_nettype none
// One step of a shift-add modular product: add the part if the low bit of the
// multiplier is set, double the part, shift the multiplier.
module mrrt_cell (
	input  wire logic                clk,
	input  wire mrrt_pkg::num_t      modulus,
	input  wire mrrt_pkg::mul_data_t din,
	output mrrt_pkg::mul_data_t      dout
);
	mrrt_pkg::mul_data_t nxt;

	always_comb begin
		nxt.acc  = din.mult[0] ? mrrt_pkg::add_mod(din.acc, din.part, modulus) : din.acc;
		nxt.part = mrrt_pkg::add_mod(din.part, din.part, modulus);
		nxt.mult = din.mult >> 1;
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end
endmodule
`default_nettype wire

>>> sv/mrrt_mulmod.sv
`default_nettype none
// Chain of NUM_WIDTH product cells, each registered. Caller keeps operands below
// the modulus; the block does not enforce it. Caller holds modulus.
module mrrt_mulmod (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire mrrt_pkg::num_t a,
	input  wire mrrt_pkg::num_t b,
	input  wire mrrt_pkg::num_t modulus,
	output logic                done,
	output mrrt_pkg::num_t      prod
);
	mrrt_pkg::mul_data_t link [mrrt_pkg::NUM_WIDTH+1];
	logic [mrrt_pkg::NUM_WIDTH-1:0] vld_q;

	assign link[0] = '{acc: '0, part: a, mult: b};

	for (genvar i = 0; i < mrrt_pkg::NUM_WIDTH; i++) begin : g_cell
		mrrt_cell u_cell (
			.clk(clk),
			.modulus(modulus),
			.din(link[i]),
			.dout(link[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[mrrt_pkg::NUM_WIDTH-2:0], start};
		end
	end

	assign done = vld_q[mrrt_pkg::NUM_WIDTH-1];
	assign prod = link[mrrt_pkg::NUM_WIDTH].acc;
endmodule
`default_nettype wire

>>> sv/miller_rabin_round_tester.sv
// One round is a witness reduction, then at most 2*NUM_WIDTH-2 modular products.
// Each product runs through the cell chain, and each factor of two is stripped
// in the split state. Candidates that are even or below two skip the cell chain.
// One round is in flight at a time; the next is taken once this one ends, and
// the verdict waits for its transfer. Reset clears the sticky failure flag, the
// state register and the busy, pass and last flags.
`default_nettype none
module miller_rabin_round_tester (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [mrrt_pkg::NUM_WIDTH-1:0]    candidate,
	input  wire logic [mrrt_pkg::NUM_WIDTH-1:0]    witness,
	input  wire logic                              last_round,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   probable_prime
);
	typedef enum logic [7:0] {
		ST_IDLE  = 8'b0000_0001,
		ST_RED   = 8'b0000_0010,
		ST_SPLIT = 8'b0000_0100,
		ST_PMUL  = 8'b0000_1000,
		ST_PSQ   = 8'b0001_0000,
		ST_CHK   = 8'b0010_0000,
		ST_SQ    = 8'b0100_0000,
		ST_DONE  = 8'b1000_0000
	} state_t;

	state_t         state_q;
	mrrt_pkg::num_t n_q, w_q, d_q, res_q, sq_q, nm1;
	mrrt_pkg::cnt_t r_q, i_q;
	logic           last_q, pass_q, failed_q, busy_q;
	logic           mstart;
	mrrt_pkg::num_t ma, mb, mprod;
	logic           mdone;

	assign nm1 = n_q - 1'b1;

	mrrt_mulmod u_mul (
		.clk(clk), .arst_n(arst_n), .start(mstart), .a(ma), .b(mb),
		.modulus(n_q), .done(mdone), .prod(mprod)
	);

	// Reduce the witness through the chain as 1 * w mod n, so every part stays below n.
	always_comb begin
		mstart = 1'b0;
		ma = sq_q;
		mb = sq_q;
		unique case (state_q)
			ST_RED: begin
				ma = {{(mrrt_pkg::NUM_WIDTH-1){1'b0}}, 1'b1}; mb = w_q;
				mstart = !busy_q;
			end
			ST_PMUL: begin
				ma = res_q; mb = sq_q; mstart = !busy_q;
			end
			ST_PSQ, ST_SQ: begin
				ma = res_q; mb = res_q;
				if (state_q == ST_PSQ) begin
					ma = sq_q; mb = sq_q;
				end
				mstart = !busy_q;
			end
			default: mstart = 1'b0;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = (state_q == ST_DONE);
	assign probable_prime = !failed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			busy_q   <= 1'b0;
			failed_q <= 1'b0;
			pass_q   <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			if (mstart) begin
				busy_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q    <= candidate;
						w_q    <= witness;
						last_q <= last_round;
						if (candidate < 2 || (!candidate[0] && candidate != 2)) begin
							pass_q  <= 1'b0;
							state_q <= ST_CHK;
						end else if (candidate == 2) begin
							pass_q  <= 1'b1;
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_RED;
						end
					end
				end
				ST_RED: begin
					if (mdone) begin
						busy_q <= 1'b0;
						sq_q   <= mprod;
						res_q  <= {{(mrrt_pkg::NUM_WIDTH-1){1'b0}}, 1'b1};
						d_q    <= nm1;
						r_q    <= '0;
						if (mprod == '0) begin
							pass_q  <= 1'b1;
							state_q <= ST_CHK;
						end else begin
							state_q <= ST_SPLIT;
						end
					end
				end
				ST_SPLIT: begin
					// strip one factor of two per cycle
					if (!d_q[0]) begin
						d_q <= d_q >> 1;
						r_q <= r_q + 1'b1;
					end else begin
						state_q <= d_q[0] ? ST_PMUL : ST_PSQ;
					end
				end
				ST_PMUL: begin
					if (mdone) begin
						busy_q  <= 1'b0;
						res_q   <= mprod;
						state_q <= ST_PSQ;
					end
				end
				ST_PSQ: begin
					if (mdone) begin
						busy_q <= 1'b0;
						sq_q   <= mprod;
						d_q    <= d_q >> 1;
						if (d_q[mrrt_pkg::NUM_WIDTH-1:1] == '0) begin
							i_q <= mrrt_pkg::cnt_t'(1);
							if (res_q == 1 || res_q == nm1) begin
								pass_q  <= 1'b1;
								state_q <= ST_CHK;
							end else if (r_q <= 1) begin
								pass_q  <= 1'b0;
								state_q <= ST_CHK;
							end else begin
								state_q <= ST_SQ;
							end
						end else begin
							state_q <= d_q[1] ? ST_PMUL : ST_PSQ;
						end
					end
				end
				ST_SQ: begin
					if (mdone) begin
						busy_q <= 1'b0;
						res_q  <= mprod;
						i_q    <= i_q + 1'b1;
						if (mprod == nm1) begin
							pass_q  <= 1'b1;
							state_q <= ST_CHK;
						end else if (mprod == 1 || i_q + 1'b1 >= r_q) begin
							pass_q  <= 1'b0;
							state_q <= ST_CHK;
						end
					end
				end
				ST_CHK: begin
					if (!pass_q) begin
						failed_q <= 1'b1;
					end
					state_q <= last_q ? ST_DONE : ST_IDLE;
				end
				ST_DONE: begin
					if (!out_stall) begin
						failed_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> tb/miller_rabin_round_tester_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module miller_rabin_round_tester_tb;
	localparam int RANDOM_ROUNDS = 80;
	localparam longint CYCLE_LIMIT = 64'd4_000_000;
	localparam int SETTLE_CYCLES = 15000;

	typedef logic [64:0] wide_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mrrt_pkg::num_t candidate = '0;
	mrrt_pkg::num_t witness = '0;
	logic last_round = 1'b0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic probable_prime;

	logic verdict_q[$];
	logic fail_sticky = 1'b0;
	int err_count = 0;
	longint cycle_count = 0;

	typedef struct {
		mrrt_pkg::num_t cand;
		mrrt_pkg::num_t wit;
		logic last;
		logic known;
		logic verdict;
	} round_row_t;

	miller_rabin_round_tester DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.candidate(candidate), .witness(witness), .last_round(last_round),
		.out_valid(out_valid), .out_stall(out_stall),
		.probable_prime(probable_prime)
	);

	always #5 clk = ~clk;

	// exact (a * b) mod n using a 65-bit accumulator
	function automatic mrrt_pkg::num_t mulmod(mrrt_pkg::num_t a, mrrt_pkg::num_t b,
		mrrt_pkg::num_t n);
		wide_t acc, part, nn;
		mrrt_pkg::num_t bb;
		acc = 0;
		nn = {2'b00, n};
		part = {2'b00, a} % nn;
		bb = b;
		while (bb != 0) begin
			if (bb[0]) begin
				acc = acc + part;
				if (acc >= nn) acc = acc - nn;
			end
			part = part + part;
			if (part >= nn) part = part - nn;
			bb = bb >> 1;
		end
		return acc[mrrt_pkg::NUM_WIDTH-1:0];
	endfunction

	function automatic logic round_passes(mrrt_pkg::num_t n, mrrt_pkg::num_t w);
		mrrt_pkg::num_t d, x, nm1, sq, e;
		int r;
		if (n < 2) return 1'b0;
		if (n == 2) return 1'b1;
		if (!n[0]) return 1'b0;
		w = w % n;
		if (w == 0) return 1'b1;
		nm1 = n - 1;
		d = nm1;
		r = 0;
		while (!d[0]) begin
			d = d >> 1;
			r++;
		end
		x = 1;
		sq = w;
		e = d;
		while (e != 0) begin
			if (e[0]) x = mulmod(x, sq, n);
			sq = mulmod(sq, sq, n);
			e = e >> 1;
		end
		if (x == 1 || x == nm1) return 1'b1;
		for (int i = 1; i < r; i++) begin
			x = mulmod(x, x, n);
			if (x == nm1) return 1'b1;
			if (x == 1) return 1'b0;
		end
		return 1'b0;
	endfunction

	task automatic predict_round(mrrt_pkg::num_t n, mrrt_pkg::num_t w, logic last);
		if (!round_passes(n, w)) fail_sticky = 1'b1;
		if (last) begin
			verdict_q.push_back(!fail_sticky);
			fail_sticky = 1'b0;
		end
	endtask

	// valid stays up through a zero gap so it is written once per edge
	task automatic send_round(mrrt_pkg::num_t n, mrrt_pkg::num_t w, logic last);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_round(n, w, last);
		in_valid <= 1'b1;
		candidate <= n;
		witness <= w;
		last_round <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic mrrt_pkg::num_t rand_num();
		return mrrt_pkg::num_t'({$urandom(), $urandom()});
	endfunction

	function automatic mrrt_pkg::num_t rand_odd(int bits);
		mrrt_pkg::num_t v;
		v = rand_num();
		if (bits < mrrt_pkg::NUM_WIDTH) v = v & ((mrrt_pkg::num_t'(1) << bits) - 1);
		v[0] = 1'b1;
		if (v < 3) v = 3;
		return v;
	endfunction

	round_row_t directed[] = '{
		'{63'd0, 63'd1, 1'b1, 1'b1, 1'b0},
		'{63'd1, 63'd1, 1'b1, 1'b1, 1'b0},
		'{63'd2, 63'd1, 1'b1, 1'b1, 1'b1},
		'{63'd2, '1, 1'b1, 1'b1, 1'b1},
		'{63'd4, 63'd3, 1'b1, 1'b1, 1'b0},
		'{'1 - 63'd1, 63'd5, 1'b1, 1'b1, 1'b0},
		'{63'd7, 63'd14, 1'b1, 1'b1, 1'b1},
		'{63'd7, 63'd2, 1'b0, 1'b0, 1'b0},
		'{63'd7, 63'd3, 1'b1, 1'b0, 1'b0},
		'{63'd9, 63'd2, 1'b0, 1'b0, 1'b0},
		'{63'd9, 63'd8, 1'b1, 1'b1, 1'b0},
		'{63'd2047, 63'd2, 1'b1, 1'b0, 1'b0},
		'{63'd2047, 63'd3, 1'b1, 1'b0, 1'b0},
		'{63'd561, 63'd2, 1'b1, 1'b0, 1'b0},
		'{63'd1000000007, 63'd2, 1'b0, 1'b0, 1'b0},
		'{63'd1000000007, 63'd1000000006, 1'b1, 1'b0, 1'b0},
		'{'1, 63'd2, 1'b1, 1'b0, 1'b0},
		'{'1, '1 - 63'd1, 1'b1, 1'b0, 1'b0},
		'{63'd9223372036854775783, 63'd2, 1'b0, 1'b0, 1'b0},
		'{63'd9223372036854775783, '1, 1'b1, 1'b0, 1'b0},
		'{63'd3, 63'd2, 1'b1, 1'b0, 1'b0}
	};

	// drain results with random stall and check in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("probable_prime: expected none, actual %0b", probable_prime);
					err_count++;
				end else begin
					logic want;
					want = verdict_q.pop_front();
					if (probable_prime !== want) begin
						$error("probable_prime: expected %0b, actual %0b", want,
							probable_prime);
						err_count++;
					end
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (out_valid && !out_stall) begin
			stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("miller_rabin_round_tester: mismatch");
			$finish;
		end
	end

	initial begin
		mrrt_pkg::num_t n;
		int left;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			if (directed[i].known) begin
				// typed expectation: check predictor agrees
				logic p;
				p = round_passes(directed[i].cand, directed[i].wit) && !fail_sticky;
				if (p !== directed[i].verdict) begin
					$error("probable_prime: expected %0b, actual %0b", directed[i].verdict, p);
					err_count++;
				end
			end
			send_round(directed[i].cand, directed[i].wit, directed[i].last);
		end
		left = RANDOM_ROUNDS;
		while (left > 0) begin
			int kind, rounds;
			kind = $urandom_range(0, 9);
			if (kind == 0) n = rand_num();
			else if (kind == 1) n = mrrt_pkg::num_t'($urandom_range(0, 40));
			else n = rand_odd($urandom_range(0, 1) ? mrrt_pkg::NUM_WIDTH : $urandom_range(8, 32));
			rounds = $urandom_range(1, 4);
			for (int k = 0; k < rounds && left > 0; k++) begin
				mrrt_pkg::num_t w;
				if ($urandom_range(0, 7) == 0) w = rand_num();
				else w = (n > 2) ? (rand_num() % (n - 1)) + 1 : 1;
				if (w == 0) w = 1;
				send_round(n, w, (k == rounds - 1) || left == 1);
				left--;
			end
		end
		in_valid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0) begin
			$display("miller_rabin_round_tester: match");
		end else begin
			$display("miller_rabin_round_tester: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire
